// ----- rtl/core/fwhc_pkg.sv -----
package fwhc_pkg;

    // Default number of bins in the counter memory.
    localparam int unsigned MAX_BINS_DEF = 256;

    // Operation codes of an input transaction.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] START_RST = 32'd0;
    localparam logic [31:0] END_RST   = 32'd256;
    localparam logic [30:0] WIDTH_RST = 31'd1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

// ----- rtl/core/fwhc_div.sv -----
module fwhc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [30:0] r_rem;
    logic [31:0] r_quo;
    logic [30:0] r_div;

    logic [31:0] trial;
    logic [31:0] trial_sub;
    logic        fits;
    logic [30:0] n_rem;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb begin
        trial     = {r_rem, r_quo[31]};
        trial_sub = trial - {1'b0, r_div};
        fits      = (trial >= {1'b0, r_div});
        n_rem     = fits ? trial_sub[30:0] : trial[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/fixed_width_histogram_counter.sv -----
// Flow: every transaction starts in PREP and ends in WRITE; a read may pass MUL, CMP and READ
// between them, and an add may also wait in DIV on the bit-serial divider. Only one
// transaction is at work at a time; a new transaction is taken while a result waits
// downstream.
// Reset: synchronous, active low. After reset a clearing pass over all MAX_BINS bins zeroes
// the counter memory, and no input transaction is accepted until it ends.
module fixed_width_histogram_counter #(
    parameter int unsigned MAX_BINS = fwhc_pkg::MAX_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_sample,
    input  logic [7:0]  i_read_index,

    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_bin_index,
    output logic [31:0] o_bin_count,
    output logic        o_index_error,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Address width of the counter memory, and the width of a bin-limit product.
    localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int unsigned PW    = IDX_W + 32;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [30:0] r_width;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= fwhc_pkg::START_RST;
            r_end   <= fwhc_pkg::END_RST;
            r_width <= fwhc_pkg::WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fwhc_pkg::REG_START: r_start <= pwdata;
                fwhc_pkg::REG_END:   r_end   <= pwdata;
                fwhc_pkg::REG_WIDTH: r_width <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fwhc_pkg::REG_START: prdata = r_start;
            fwhc_pkg::REG_END:   prdata = r_end;
            fwhc_pkg::REG_WIDTH: prdata = {1'b0, r_width};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and captured transaction.
    // ------------------------------------------------------------------
    fwhc_pkg::t_state r_state;
    fwhc_pkg::t_state n_state;

    logic             r_op;
    logic [31:0]      r_sample;
    logic [7:0]       r_ridx;
    logic             r_mode_end;   // the sample lies at or above range_end
    logic             r_err;
    logic [IDX_W-1:0] r_k;          // candidate bin checked against the bin limit
    logic [IDX_W-1:0] r_bin;
    logic [PW-1:0]    r_prod;
    logic [IDX_W-1:0] r_clr;
    logic [31:0]      r_rdata;

    logic             r_ovalid;
    logic [7:0]       r_oidx;
    logic [31:0]      r_ocount;
    logic             r_oerr;

    logic             in_acc;
    logic             out_free;

    assign o_stall  = (r_state != fwhc_pkg::ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // Range arithmetic on the captured sample. A zero bin width counts as one.
    logic signed [32:0] span;
    logic signed [32:0] diff;
    logic               span_pos;
    logic               below;
    logic               above;
    logic [30:0]        wz;
    logic [31:0]        dividend;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [IDX_W:0]     k_inc;
    logic [PW-1:0]      span_ext;
    logic               over_limit;
    logic [31:0]        new_count;
    logic               is_last_clr;

    always_comb begin
        span      = $signed({r_end[31], r_end}) - $signed({r_start[31], r_start});
        diff      = $signed({r_sample[31], r_sample}) - $signed({r_start[31], r_start});
        span_pos  = !span[32] && (span != 33'sd0);
        below     = $signed(r_sample) < $signed(r_start);
        above     = $signed(r_sample) >= $signed(r_end);
        wz        = (r_width == 31'd0) ? 31'd1 : r_width;
        // At or above the end the last bin in use is floor(span / width) - 1.
        dividend  = above ? span[31:0] : diff[31:0];
        div_start = (r_state == fwhc_pkg::ST_PREP) && (r_op == fwhc_pkg::OP_ADD)
                    && !below && span_pos;
        k_inc     = {1'b0, r_k} + (IDX_W + 1)'(1);
        span_ext  = PW'(span[31:0]);
        // For a candidate bin k below MAX_BINS, k is at or past the bin limit
        // exactly when span < (k + 1) * width, or when the range is empty.
        over_limit = !span_pos || (span_ext < r_prod);
        new_count  = (r_rdata == fwhc_pkg::COUNT_MAX) ? r_rdata : r_rdata + 32'd1;
        is_last_clr = (r_clr == IDX_W'(MAX_BINS - 1));
    end

    fwhc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (wz),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwhc_pkg::ST_CLEAR: begin
                if (is_last_clr) begin
                    n_state = fwhc_pkg::ST_IDLE;
                end
            end
            fwhc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = fwhc_pkg::ST_PREP;
                end
            end
            fwhc_pkg::ST_PREP: begin
                if (r_op == fwhc_pkg::OP_READ) begin
                    if (r_ridx == 8'd0) begin
                        n_state = fwhc_pkg::ST_READ;
                    end else if (32'(r_ridx) >= 32'(MAX_BINS)) begin
                        n_state = fwhc_pkg::ST_WRITE;
                    end else begin
                        n_state = fwhc_pkg::ST_MUL;
                    end
                end else if (below || !span_pos) begin
                    n_state = fwhc_pkg::ST_READ;
                end else begin
                    n_state = fwhc_pkg::ST_DIV;
                end
            end
            fwhc_pkg::ST_DIV: begin
                if (div_done) begin
                    if (div_quo == 32'd0 || div_quo >= 32'(MAX_BINS) || r_mode_end) begin
                        n_state = fwhc_pkg::ST_READ;
                    end else begin
                        n_state = fwhc_pkg::ST_MUL;
                    end
                end
            end
            fwhc_pkg::ST_MUL: n_state = fwhc_pkg::ST_CMP;
            fwhc_pkg::ST_CMP: begin
                if (r_op == fwhc_pkg::OP_READ && over_limit) begin
                    n_state = fwhc_pkg::ST_WRITE;
                end else begin
                    n_state = fwhc_pkg::ST_READ;
                end
            end
            fwhc_pkg::ST_READ: n_state = fwhc_pkg::ST_WRITE;
            fwhc_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = fwhc_pkg::ST_IDLE;
                end
            end
            default: n_state = fwhc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fwhc_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fwhc_pkg::ST_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (r_state == fwhc_pkg::ST_WRITE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers of the transaction at work.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fwhc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_op     <= i_operation;
                    r_sample <= i_sample;
                    r_ridx   <= i_read_index;
                    r_err    <= 1'b0;
                end
            end
            fwhc_pkg::ST_PREP: begin
                r_mode_end <= above;
                if (r_op == fwhc_pkg::OP_READ) begin
                    r_k   <= IDX_W'(r_ridx);
                    r_bin <= '0;
                    if (r_ridx != 8'd0 && 32'(r_ridx) >= 32'(MAX_BINS)) begin
                        r_err <= 1'b1;
                    end
                end else begin
                    r_bin <= '0;
                end
            end
            fwhc_pkg::ST_DIV: begin
                if (div_done) begin
                    if (div_quo == 32'd0) begin
                        r_bin <= '0;
                    end else if (div_quo >= 32'(MAX_BINS)) begin
                        r_bin <= IDX_W'(MAX_BINS - 1);
                    end else if (r_mode_end) begin
                        r_bin <= IDX_W'(div_quo - 32'd1);
                    end else begin
                        r_k <= IDX_W'(div_quo);
                    end
                end
            end
            fwhc_pkg::ST_MUL: r_prod <= PW'(k_inc) * PW'(wz);
            fwhc_pkg::ST_CMP: begin
                if (r_op == fwhc_pkg::OP_READ) begin
                    r_bin <= r_k;
                    r_err <= over_limit;
                end else begin
                    r_bin <= over_limit ? r_k - IDX_W'(1) : r_k;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Counter memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [31:0]      mem [MAX_BINS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wd;

    always_comb begin
        if (r_state == fwhc_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else begin
            mem_we = (r_state == fwhc_pkg::ST_WRITE) && out_free
                     && (r_op == fwhc_pkg::OP_ADD);
            mem_wa = r_bin;
            mem_wd = new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (r_state == fwhc_pkg::ST_READ) begin
            r_rdata <= mem[r_bin];
        end
    end

    // Result register; it holds while the downstream side stalls.
    always_ff @(posedge i_clk) begin
        if (r_state == fwhc_pkg::ST_WRITE && out_free) begin
            if (r_op == fwhc_pkg::OP_READ) begin
                r_oidx   <= r_ridx;
                r_ocount <= r_err ? 32'd0 : r_rdata;
                r_oerr   <= r_err;
            end else begin
                r_oidx   <= 8'(r_bin);
                r_ocount <= new_count;
                r_oerr   <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_bin_index   = r_oidx;
    assign o_bin_count   = r_ocount;
    assign o_index_error = r_oerr;

endmodule
